// ===== src/ber_definite_to_indefinite_top_defines.svh =====
// ----------------------------------------------------------------------------
// ber definite to indefinite: assertion macros
// Shared concurrent assertion helpers for the converter.
// ----------------------------------------------------------------------------
`ifndef BER_DEFINITE_TO_INDEFINITE_TOP_DEFINES_SVH
`define BER_DEFINITE_TO_INDEFINITE_TOP_DEFINES_SVH

// same-cycle implication
`define BER_D2I_ASSERT_NOW(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error(msg);

// next-cycle implication
`define BER_D2I_ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error(msg);

`endif

// ===== src/ber_d2i_pkg.sv =====
// ----------------------------------------------------------------------------
// ber_d2i_pkg
// Constants, types and codes of the definite to indefinite length converter.
// ----------------------------------------------------------------------------
package ber_d2i_pkg;

  localparam int MAX_DEPTH = 16;
  localparam int LEN_BITS  = 32;
  localparam int TOP_W     = $clog2(MAX_DEPTH + 1);
  localparam int NEST_W    = 5;
  localparam int HDR_W     = 5;
  localparam int CLEN_W    = 32;

  typedef enum logic [1:0] {
    KIND_COPY  = 2'd0,
    KIND_INDEF = 2'd1,
    KIND_EOC   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    OP_HOLD = 2'd0,
    OP_PUSH = 2'd1,
    OP_POP  = 2'd2
  } cell_op_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_EVAL  = 2'd1,
    ST_CLOSE = 2'd2
  } state_e;

  typedef struct packed {
    logic [LEN_BITS-1:0] len;
    logic [LEN_BITS-1:0] cnt;
  } lvl_t;

  typedef struct packed {
    cell_op_e            op;
    logic [LEN_BITS-1:0] push_len;
    logic [LEN_BITS-1:0] head_add;
    logic [LEN_BITS-1:0] second_add;
  } stack_ctl_t;

endpackage

// ===== src/ber_d2i_in_if.sv =====
// ----------------------------------------------------------------------------
// ber_d2i_in_if
// Request channel carrying one decoded element header.
// ----------------------------------------------------------------------------
interface ber_d2i_in_if
  import ber_d2i_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              is_constructed;
  logic              is_indef_in;
  logic [HDR_W-1:0]  header_bytes;
  logic [CLEN_W-1:0] content_bytes;

  modport source (
    output valid, is_constructed, is_indef_in, header_bytes, content_bytes,
    input  ready
  );

  modport sink (
    input  valid, is_constructed, is_indef_in, header_bytes, content_bytes,
    output ready
  );
endinterface

// ===== src/ber_d2i_out_if.sv =====
// ----------------------------------------------------------------------------
// ber_d2i_out_if
// Result channel carrying one emitted piece of the converted stream.
// ----------------------------------------------------------------------------
interface ber_d2i_out_if
  import ber_d2i_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic              last;
  logic [NEST_W-1:0] nest_level;
  logic              overflow;

  modport source (
    output valid, kind, last, nest_level, overflow,
    input  ready
  );

  modport sink (
    input  valid, kind, last, nest_level, overflow,
    output ready
  );
endinterface

// ===== src/ber_d2i_cell.sv =====
// ----------------------------------------------------------------------------
// ber_d2i_cell
// One stack level: length and byte count, shifts with its neighbors.
// ----------------------------------------------------------------------------
module ber_d2i_cell
  import ber_d2i_pkg::*;
(
  input  logic                clk_i,
  input  cell_op_e            op_i,
  input  logic [LEN_BITS-1:0] addend_i,
  input  lvl_t                left_i,
  input  lvl_t                right_i,
  output lvl_t                lvl_o
);

  lvl_t lvl_q, lvl_d, sel;

  always_comb begin
    case (op_i)
      OP_PUSH: sel = left_i;
      OP_POP:  sel = right_i;
      default: sel = lvl_q;
    endcase
    lvl_d.len = sel.len;
    lvl_d.cnt = sel.cnt + addend_i;
  end

  always_ff @(posedge clk_i) begin
    lvl_q <= lvl_d;
  end

  assign lvl_o = lvl_q;

endmodule

// ===== src/ber_d2i_stack.sv =====
// ----------------------------------------------------------------------------
// ber_d2i_stack
// Row of level cells; the innermost open level sits in the head cell.
// ----------------------------------------------------------------------------
module ber_d2i_stack
  import ber_d2i_pkg::*;
(
  input  logic       clk_i,
  input  stack_ctl_t ctl_i,
  output lvl_t       head_o
);

  lvl_t lvl [MAX_DEPTH];

  for (genvar i = 0; i < MAX_DEPTH; i++) begin : g_cell
    lvl_t                left, right;
    logic [LEN_BITS-1:0] addend;

    if (i == 0) begin : g_head
      assign left   = '{len: ctl_i.push_len, cnt: '0};
      assign addend = ctl_i.head_add;
    end else if (i == 1) begin : g_second
      assign left   = lvl[i-1];
      assign addend = ctl_i.second_add;
    end else begin : g_rest
      assign left   = lvl[i-1];
      assign addend = '0;
    end

    if (i == MAX_DEPTH - 1) begin : g_tail
      assign right = '0;
    end else begin : g_mid
      assign right = lvl[i+1];
    end

    ber_d2i_cell u_cell (
      .clk_i    (clk_i),
      .op_i     (ctl_i.op),
      .addend_i (addend),
      .left_i   (left),
      .right_i  (right),
      .lvl_o    (lvl[i])
    );
  end

  assign head_o = lvl[0];

endmodule

// ===== src/ber_definite_to_indefinite_top.sv =====
// ----------------------------------------------------------------------------
// ber_definite_to_indefinite_top
// Re-emits definite constructed headers as indefinite if the stack has room
// and inserts the end-of-contents markers where each definite level closes.
//
// in_i carries one decoded header per request; out_o carries the pieces
// of the converted stream, the final one of a header flagged by last.
// A header is taken in ST_IDLE; in ST_EVAL, once the output register is free,
// its own result is loaded there, and each level it closes adds an
// end-of-contents marker, emitted from ST_CLOSE. The loop behind this is the
// pop of the head cell of the level stack, one level per cycle while the
// receiver does not stall, with the compare on the head cell.
// Input is taken only between headers; a single output register lets a
// header be taken while the previous result still waits.
// When the receiver stalls, the pending result holds and the block waits.
// Reset empties the stack and drops any pending result.
// ----------------------------------------------------------------------------
`include "ber_definite_to_indefinite_top_defines.svh"

module ber_definite_to_indefinite_top
  import ber_d2i_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  ber_d2i_in_if.sink   in_i,
  ber_d2i_out_if.source out_o
);

  state_e            state_q, state_d;
  logic [TOP_W-1:0]  top_q, top_d;
  kind_e             item_kind_q, item_kind_d;
  logic              item_ovf_q, item_ovf_d;
  logic              out_valid_q, out_valid_d;
  kind_e             out_kind_q, out_kind_d;
  logic              out_last_q, out_last_d;
  logic [NEST_W-1:0] out_nest_q, out_nest_d;
  logic              out_ovf_q, out_ovf_d;

  stack_ctl_t ctl;
  lvl_t       head;
  logic       slot_free, close_c, def_cons, push_c, emit;

  ber_d2i_stack u_stack (
    .clk_i    (clk_i),
    .ctl_i    (ctl),
    .head_o   (head)
  );

  assign slot_free = !out_valid_q || out_o.ready;
  assign close_c   = (top_q != '0) && (head.len == head.cnt);
  assign def_cons  = in_i.is_constructed && !in_i.is_indef_in;
  assign push_c    = def_cons && (top_q < TOP_W'(MAX_DEPTH));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) state_d = ST_EVAL;
      end
      ST_EVAL, ST_CLOSE: begin
        if (slot_free) state_d = close_c ? ST_CLOSE : ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    ctl         = '{op: OP_HOLD, push_len: '0, head_add: '0, second_add: '0};
    top_d       = top_q;
    item_kind_d = item_kind_q;
    item_ovf_d  = item_ovf_q;
    emit        = 1'b0;
    out_kind_d  = out_kind_q;
    out_last_d  = out_last_q;
    out_nest_d  = out_nest_q;
    out_ovf_d   = out_ovf_q;
    in_i.ready  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          item_ovf_d  = def_cons && !push_c;
          item_kind_d = push_c ? KIND_INDEF : KIND_COPY;
          if (!in_i.is_constructed) begin
            ctl.head_add = LEN_BITS'(in_i.header_bytes) + LEN_BITS'(in_i.content_bytes);
          end else if (push_c) begin
            ctl.op         = OP_PUSH;
            ctl.push_len   = LEN_BITS'(in_i.content_bytes);
            ctl.second_add = LEN_BITS'(in_i.header_bytes);
            top_d          = top_q + 1'b1;
          end else begin
            ctl.head_add = LEN_BITS'(in_i.header_bytes);
          end
        end
      end
      ST_EVAL, ST_CLOSE: begin
        if (slot_free) begin
          emit       = 1'b1;
          out_kind_d = (state_q == ST_EVAL) ? item_kind_q : KIND_EOC;
          out_last_d = !close_c;
          out_nest_d = NEST_W'(top_q);
          out_ovf_d  = item_ovf_q;
          if (close_c) begin
            ctl.op       = OP_POP;
            ctl.head_add = head.len;
            top_d        = top_q - 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  assign out_valid_d = emit ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      top_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      top_q       <= top_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_kind_q <= item_kind_d;
    item_ovf_q  <= item_ovf_d;
    out_kind_q  <= out_kind_d;
    out_last_q  <= out_last_d;
    out_nest_q  <= out_nest_d;
    out_ovf_q   <= out_ovf_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.kind       = out_kind_q;
  assign out_o.last       = out_last_q;
  assign out_o.nest_level = out_nest_q;
  assign out_o.overflow   = out_ovf_q;

  `BER_D2I_ASSERT_NOW(a_depth_bound, clk_i, rst_ni, 1'b1, top_q <= TOP_W'(MAX_DEPTH),
    "stack depth beyond limit")
  `BER_D2I_ASSERT_NOW(a_pop_nonempty, clk_i, rst_ni, ctl.op == OP_POP, top_q != '0,
    "pop on empty stack")
  `BER_D2I_ASSERT_NEXT(a_accept_eval, clk_i, rst_ni, in_i.valid && in_i.ready,
    state_q == ST_EVAL, "accepted request not evaluated")
  `BER_D2I_ASSERT_NOW(a_indef_no_ovf, clk_i, rst_ni,
    out_o.valid && (out_o.kind == KIND_INDEF), !out_o.overflow,
    "rewritten header flagged as overflow")

endmodule
